>>> rtl/srms_pkg.sv
package srms_pkg;

	// width of the shared subtract/compare unit (covers divide and root steps)
	localparam int SUB_W = 18;

	// operand width of the shared multiplier
	localparam int MUL_W = 16;

	// radicand and result widths of the root
	localparam int MEAN_W = 32;
	localparam int RMS_W = 16;
	localparam int SQRT_STEPS = 16;

	// smoothing weight after reset, about 0.07 in Q0.16
	localparam logic [15:0] WEIGHT_RESET = 16'd4588;

	// one half in Q0.16 product scale, for round to nearest
	localparam logic [31:0] ROUND_HALF = 32'd32768;

	// result of the shared subtractor
	typedef struct packed {
		logic [SUB_W-1:0] diff;
		logic             borrow;
	} sub_res_t;

endpackage

>>> rtl/srms_sub_unit.sv
module srms_sub_unit (
	input  logic [srms_pkg::SUB_W-1:0] a,
	input  logic [srms_pkg::SUB_W-1:0] b,
	output srms_pkg::sub_res_t         res
);

	logic [srms_pkg::SUB_W:0] full;

	// subtract with one extra bit; the top bit is the borrow (a < b)
	assign full = {1'b0, a} - {1'b0, b};
	assign res.diff = full[srms_pkg::SUB_W-1:0];
	assign res.borrow = full[srms_pkg::SUB_W];

endmodule

>>> rtl/srms_mul_unit.sv
module srms_mul_unit (
	input  logic                           clk,
	input  logic [srms_pkg::MUL_W-1:0]     a,
	input  logic [srms_pkg::MUL_W-1:0]     b,
	output logic [2*srms_pkg::MUL_W-1:0]   product
);

	logic [2*srms_pkg::MUL_W-1:0] product_q;

	// unsigned product, registered
	always_ff @(posedge clk) begin
		product_q <= a * b;
	end

	assign product = product_q;

endmodule

>>> rtl/stereo_rms_level_meter.sv
// Stereo RMS level meter with exponential smoothing.
// Input channel (in_valid / in_stall): one stereo frame per word, signed
// left_sample and right_sample, and last_in_buffer to close the buffer. A buffer
// reaching MAX_FRAMES frames closes as if last_in_buffer were set.
// Output channel (out_valid / out_stall): one word per closed buffer with
// rms_level and smoothed_level (unsigned Q0.16) and the wrapping buffer_number.
// Config channel (cfg_valid / cfg_ready): writes smoothing_weight (Q0.16);
// write it only while the block is idle.
// Sequence: for each frame one 16x16 multiplier squares left, then right,
// then the squares accumulate. A closing frame then goes on to its result:
// the shared subtractor runs one restoring divide step per cycle over the
// scaled sum (NUM_W bits), then 16 square root steps, then the average update
// through the same subtractor and multiplier. in_stall stays high meanwhile.
// The result sits in an output register; a new frame is accepted while it
// waits. If the receiver stalls, the next closing frame waits for that
// register to empty before its result is loaded.
// Reset clears the sums, average, buffer count and weight (back to 0.07).
module stereo_rms_level_meter #(
	parameter int MAX_FRAMES  = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] left_sample,
	input  logic signed [15:0] right_sample,
	input  logic               last_in_buffer,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        rms_level,
	output logic [15:0]        smoothed_level,
	output logic [31:0]        buffer_number,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        smoothing_weight
);

	localparam int SB      = SAMPLE_BITS;
	localparam int FR_W    = $clog2(MAX_FRAMES + 1);
	localparam int TALLY_W = FR_W + 1;
	localparam int SQ_BITS = (SB > 16) ? 32 : 2 * SB - 1;
	localparam int SQ_W    = SQ_BITS + TALLY_W;
	localparam int SHL     = (2 * SB <= 32) ? 32 - 2 * SB : 0;
	localparam int SHR     = (2 * SB > 32) ? 2 * SB - 32 : 0;
	localparam int WIDE_W  = SQ_W + SHL;
	localparam int NUM_W   = WIDE_W - SHR;
	localparam int CNT_W   = $clog2(((NUM_W > 16) ? NUM_W : 16) + 1);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SQL  = 4'd1;
	localparam logic [3:0] ST_SQR  = 4'd2;
	localparam logic [3:0] ST_ACC  = 4'd3;
	localparam logic [3:0] ST_LOAD = 4'd4;
	localparam logic [3:0] ST_DIV  = 4'd5;
	localparam logic [3:0] ST_ROOT = 4'd6;
	localparam logic [3:0] ST_CMP  = 4'd7;
	localparam logic [3:0] ST_DIFF = 4'd8;
	localparam logic [3:0] ST_MUL  = 4'd9;
	localparam logic [3:0] ST_UPD  = 4'd10;
	localparam logic [3:0] ST_OUT  = 4'd11;

	logic [3:0]                       state_q;
	logic [15:0]                      weight_q;
	logic [15:0]                      left_q, right_q;
	logic                             close_q;
	logic [FR_W-1:0]                  frames_q;
	logic [SQ_W-1:0]                  sum_q;
	logic [NUM_W-1:0]                 num_q;
	logic [srms_pkg::MEAN_W-1:0]      quot_q;
	logic [srms_pkg::SUB_W-1:0]       rem_q;
	logic [srms_pkg::RMS_W-1:0]       root_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic                             neg_q;
	logic [15:0]                      diff_q;
	logic [15:0]                      avg_q;
	logic [31:0]                      tally_q;
	logic                             out_valid_q;
	logic [15:0]                      rms_q, smooth_q;

	logic                             in_acc;
	logic [FR_W-1:0]                  frames_nx;
	logic [TALLY_W-1:0]               tally;
	logic [SB-1:0]                    val_l, val_r, mfull_l, mfull_r;
	logic [srms_pkg::MUL_W-1:0]       mag_l, mag_r;
	logic [srms_pkg::MUL_W-1:0]       mul_a, mul_b;
	logic [2*srms_pkg::MUL_W-1:0]     prod;
	logic [srms_pkg::SUB_W-1:0]       sub_a, sub_b;
	srms_pkg::sub_res_t               sub_res;
	logic [WIDE_W-1:0]                sum_wide;
	logic [NUM_W-1:0]                 num_init;
	logic [31:0]                      rounded;
	logic [15:0]                      delta;
	logic                             out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign frames_nx = frames_q + FR_W'(1);
	assign tally     = {frames_q, 1'b0};
	assign out_free  = !out_valid_q || !out_stall;

	// sample magnitudes; wide sample formats see the field as non-negative
	if (SB <= 16) begin : g_narrow
		assign val_l = left_q[SB-1:0];
		assign val_r = right_q[SB-1:0];
	end else begin : g_wide
		assign val_l = {{(SB - 16){1'b0}}, left_q};
		assign val_r = {{(SB - 16){1'b0}}, right_q};
	end
	assign mfull_l = val_l[SB-1] ? SB'(0) - val_l : val_l;
	assign mfull_r = val_r[SB-1] ? SB'(0) - val_r : val_r;
	assign mag_l   = srms_pkg::MUL_W'(mfull_l);
	assign mag_r   = srms_pkg::MUL_W'(mfull_r);

	// scale the sum to Q0.32 before the divide
	assign sum_wide = WIDE_W'(sum_q) << SHL;
	assign num_init = NUM_W'(sum_wide >> SHR);

	// multiplier operand select
	always_comb begin
		case (state_q)
			ST_SQL: begin
				mul_a = mag_l;
				mul_b = mag_l;
			end
			ST_SQR: begin
				mul_a = mag_r;
				mul_b = mag_r;
			end
			ST_MUL: begin
				mul_a = weight_q;
				mul_b = diff_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// subtractor operand select
	always_comb begin
		case (state_q)
			ST_DIV: begin
				sub_a = srms_pkg::SUB_W'({rem_q[TALLY_W-1:0], num_q[NUM_W-1]});
				sub_b = srms_pkg::SUB_W'(tally);
			end
			ST_ROOT: begin
				sub_a = {rem_q[15:0], quot_q[31:30]};
				sub_b = {root_q, 2'b01};
			end
			ST_CMP: begin
				sub_a = srms_pkg::SUB_W'(root_q);
				sub_b = srms_pkg::SUB_W'(avg_q);
			end
			ST_DIFF: begin
				sub_a = neg_q ? srms_pkg::SUB_W'(avg_q) : srms_pkg::SUB_W'(root_q);
				sub_b = neg_q ? srms_pkg::SUB_W'(root_q) : srms_pkg::SUB_W'(avg_q);
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end

	srms_mul_unit u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.product (prod)
	);

	srms_sub_unit u_sub (
		.a   (sub_a),
		.b   (sub_b),
		.res (sub_res)
	);

	// rounded weight step
	assign rounded = prod + srms_pkg::ROUND_HALF;
	assign delta   = rounded[31:16];

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			weight_q    <= srms_pkg::WEIGHT_RESET;
			frames_q    <= '0;
			sum_q       <= '0;
			avg_q       <= '0;
			tally_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				weight_q <= smoothing_weight;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						frames_q <= frames_nx;
						state_q  <= ST_SQL;
					end
				end
				ST_SQL: begin
					state_q <= ST_SQR;
				end
				ST_SQR: begin
					sum_q   <= sum_q + SQ_W'(prod);
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					sum_q   <= sum_q + SQ_W'(prod);
					state_q <= close_q ? ST_LOAD : ST_IDLE;
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (cnt_q == CNT_W'(srms_pkg::SQRT_STEPS - 1)) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					avg_q   <= neg_q ? avg_q - delta : avg_q + delta;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						tally_q     <= tally_q + 32'd1;
						sum_q       <= '0;
						frames_q    <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers of the frame capture, divide, root and average steps and result word
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					left_q  <= left_sample;
					right_q <= right_sample;
					close_q <= last_in_buffer || (frames_nx == FR_W'(MAX_FRAMES));
				end
			end
			ST_LOAD: begin
				num_q  <= num_init;
				quot_q <= '0;
				rem_q  <= '0;
				cnt_q  <= '0;
			end
			ST_DIV: begin
				num_q  <= num_q << 1;
				quot_q <= {quot_q[30:0], ~sub_res.borrow};
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= '0;
				end else begin
					rem_q <= sub_res.borrow ? sub_a : sub_res.diff;
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			ST_ROOT: begin
				quot_q <= quot_q << 2;
				rem_q  <= sub_res.borrow ? sub_a : sub_res.diff;
				root_q <= {root_q[14:0], ~sub_res.borrow};
				cnt_q  <= cnt_q + CNT_W'(1);
			end
			ST_CMP: begin
				neg_q <= sub_res.borrow;
			end
			ST_DIFF: begin
				diff_q <= sub_res.diff[15:0];
			end
			ST_OUT: begin
				if (out_free) begin
					rms_q    <= root_q;
					smooth_q <= avg_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign rms_level      = rms_q;
	assign smoothed_level = smooth_q;
	assign buffer_number  = tally_q;

	// an accepted frame keeps the input stalled on the next cycle
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("input not stalled after accepting a frame");

	// the frame count never runs past the buffer limit
	a_frames_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frames_q <= FR_W'(MAX_FRAMES))
		else $error("frame count beyond MAX_FRAMES");

	// the partial remainder stays below the divisor during the divide
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < srms_pkg::SUB_W'(tally))
		else $error("divide remainder out of range");

	// the average never passes full scale of the halved samples
	a_avg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		avg_q <= 16'd32768)
		else $error("smoothed level out of range");

	// the buffer count advances exactly when a result word is loaded
	a_tally_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> tally_q == $past(tally_q) + 32'd1)
		else $error("buffer count did not advance with a result");

endmodule

>>> sim/tb_stereo_rms_level_meter.sv
module tb_stereo_rms_level_meter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_FRAMES   = 256;
	localparam int SAMPLE_BITS  = 16;
	// margin left after the last result before a weight write
	localparam int SETTLE_CYCLES = 100;

	typedef struct {
		logic [15:0] rms;
		logic [15:0] smoothed;
		logic [31:0] number;
	} level_word_t;

	// Predicts the meter: accumulates squares per buffer, closes on last or
	// on the MAX_FRAMES-th frame, and keeps the queue of expected level words.
	class level_scoreboard;
		logic [15:0] weight;
		logic [41:0] sum_sq;
		logic [13:0] n_samples;
		logic [15:0] avg_level;
		logic [31:0] buf_count;
		level_word_t expected_q[$];
		int errors;

		function new();
			weight    = srms_pkg::WEIGHT_RESET;
			sum_sq    = '0;
			n_samples = '0;
			avg_level = '0;
			buf_count = '0;
			errors    = 0;
		endfunction

		function void set_weight(logic [15:0] w);
			weight = w;
		endfunction

		// magnitude squared of one sample, two's complement at SAMPLE_BITS
		function logic [63:0] square_of(logic [15:0] raw);
			logic [63:0] full, v, mag;
			full = 64'd1 << SAMPLE_BITS;
			v    = 64'(raw) & (full - 64'd1);
			mag  = v[SAMPLE_BITS-1] ? (full - v) : v;
			return mag * mag;
		endfunction

		function void note_frame(logic [15:0] l, logic [15:0] r, logic lst);
			logic [63:0] num, mean, root, cand, diff, step;
			logic [15:0] rms;
			level_word_t w;
			sum_sq    = sum_sq + 42'(square_of(l)) + 42'(square_of(r));
			n_samples = n_samples + 14'd2;
			if (!lst && int'(n_samples >> 1) < MAX_FRAMES)
				return;

			// mean square in Q0.32, halving folded into the scale
			if (2 * SAMPLE_BITS <= 32)
				num = 64'(sum_sq) << (32 - 2 * SAMPLE_BITS);
			else
				num = 64'(sum_sq) >> (2 * SAMPLE_BITS - 32);
			mean = num / 64'(n_samples);

			// floor square root, one result bit per pass
			root = '0;
			for (int i = 31; i >= 0; i--) begin
				cand = root | (64'd1 << i);
				if (cand * cand <= mean)
					root = cand;
			end
			if (root > 64'hFFFF)
				root = 64'hFFFF;
			rms = root[15:0];

			// exponential average, step rounded half away from zero
			if (rms >= avg_level) begin
				diff      = 64'(rms - avg_level);
				step      = (64'(weight) * diff + 64'd32768) >> 16;
				avg_level = avg_level + step[15:0];
			end else begin
				diff      = 64'(avg_level - rms);
				step      = (64'(weight) * diff + 64'd32768) >> 16;
				avg_level = avg_level - step[15:0];
			end

			buf_count  = buf_count + 32'd1;
			sum_sq     = '0;
			n_samples  = '0;
			w.rms      = rms;
			w.smoothed = avg_level;
			w.number   = buf_count;
			expected_q = {expected_q, w};
		endfunction

		function void check_result(logic [15:0] rms, logic [15:0] smoothed, logic [31:0] number);
			level_word_t w;
			if (expected_q.size() == 0) begin
				$error("unexpected level word: rms_level %0d smoothed_level %0d buffer_number %0d",
					rms, smoothed, number);
				errors++;
				return;
			end
			w = expected_q.pop_front();
			if (rms !== w.rms) begin
				$error("rms_level: expected %0d, actual %0d", w.rms, rms);
				errors++;
			end
			if (smoothed !== w.smoothed) begin
				$error("smoothed_level: expected %0d, actual %0d", w.smoothed, smoothed);
				errors++;
			end
			if (number !== w.number) begin
				$error("buffer_number: expected %0d, actual %0d", w.number, number);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n         = 1'b0;
	logic               in_valid       = 1'b0;
	logic               in_stall;
	logic signed [15:0] left_sample    = '0;
	logic signed [15:0] right_sample   = '0;
	logic               last_in_buffer = 1'b0;
	logic               out_valid;
	logic               out_stall      = 1'b0;
	logic [15:0]        rms_level;
	logic [15:0]        smoothed_level;
	logic [31:0]        buffer_number;
	logic               cfg_valid      = 1'b0;
	logic               cfg_ready;
	logic [15:0]        smoothing_weight = '0;

	int src_idle_pct   = 0;
	int sink_stall_pct = 0;

	level_scoreboard meter = new();

	stereo_rms_level_meter #(
		.MAX_FRAMES  (MAX_FRAMES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.left_sample      (left_sample),
		.right_sample     (right_sample),
		.last_in_buffer   (last_in_buffer),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.rms_level        (rms_level),
		.smoothed_level   (smoothed_level),
		.buffer_number    (buffer_number),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.smoothing_weight (smoothing_weight)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			meter.check_result(rms_level, smoothed_level, buffer_number);
	end

	// one stereo frame; starts and ends at a falling edge, valid left high
	task automatic send_frame(input logic signed [15:0] l, input logic signed [15:0] r,
		input logic lst);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		left_sample    <= l;
		right_sample   <= r;
		last_in_buffer <= lst;
		do @(posedge clk); while (in_stall);
		meter.note_frame(l, r, lst);
		@(negedge clk);
	endtask

	// drop valid and wait for every expected word; called right after send_frame
	task automatic drain_results(input int extra);
		in_valid <= 1'b0;
		do @(negedge clk); while (meter.pending() != 0);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_weight(input logic [15:0] w);
		cfg_valid        <= 1'b1;
		smoothing_weight <= w;
		do @(posedge clk); while (!cfg_ready);
		meter.set_weight(w);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [15:0] gen_sample(input int style);
		int t;
		case (style)
			0: t = int'($urandom_range(0, 65535));
			1: t = int'($urandom_range(0, 1023)) - 512;
			2: begin
				case ($urandom_range(0, 4))
					0: t = -32768;
					1: t = 32767;
					2: t = -1;
					3: t = 1;
					default: t = 0;
				endcase
			end
			default: begin
				t = int'($urandom_range(16384, 32767));
				if ($urandom_range(0, 1) == 1)
					t = -t - 1;
			end
		endcase
		return t[15:0];
	endfunction

	// random buffers until the frame budget is spent; phase ends on a closed buffer
	task automatic run_phase(input int budget, input int src_idle, input int sink_stall,
		input bit hold_once);
		int sent;
		int len;
		int style;
		bit close_it;
		logic lst;
		src_idle_pct   = src_idle;
		sink_stall_pct = sink_stall;
		sent = 0;
		while (sent < budget) begin
			// mostly short buffers, now and then one with a length around the frame limit
			if ($urandom_range(0, 39) == 0)
				len = $urandom_range(MAX_FRAMES - 6, MAX_FRAMES + 6);
			else
				len = $urandom_range(1, 12);
			close_it = ($urandom_range(0, 9) != 0);
			style    = $urandom_range(0, 3);
			for (int k = 0; k < len; k++) begin
				lst = close_it && (k == len - 1);
				// stray last marks break a buffer early
				if ($urandom_range(0, 49) == 0)
					lst = 1'b1;
				send_frame(gen_sample(style), gen_sample(style), lst);
			end
			sent += len;
			if (hold_once && sent > budget / 2) begin
				hold_once = 1'b0;
				drain_results(0);
			end
		end
		send_frame(gen_sample(0), gen_sample(0), 1'b1);
		drain_results(SETTLE_CYCLES);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frames at the reset weight
		src_idle_pct   = 19;
		sink_stall_pct = 61;
		send_frame(16'sd32767, -16'sd32768, 1'b1);
		send_frame(16'sd0, 16'sd0, 1'b1);
		send_frame(-16'sd32768, -16'sd32768, 1'b1);
		send_frame(-16'sd32768, -16'sd32768, 1'b1);
		send_frame(-16'sd1, 16'sd1, 1'b1);
		send_frame(16'sd32767, 16'sd32767, 1'b0);
		send_frame(16'sd32767, 16'sd32767, 1'b0);
		send_frame(16'sd32767, 16'sd32767, 1'b0);
		send_frame(-16'sd32768, 16'sd0, 1'b1);
		send_frame(16'sh5555, 16'shAAAA, 1'b0);
		send_frame(16'shAAAA, 16'sh5555, 1'b1);
		send_frame(16'sd0, -16'sd32768, 1'b1);
		send_frame(16'sd1, -16'sd1, 1'b0);
		send_frame(16'sd0, 16'sd0, 1'b1);
		send_frame(16'sd0, 16'sd0, 1'b1);
		drain_results(SETTLE_CYCLES);

		write_weight(16'hFFFF);
		run_phase(360, 19, 61, 1'b1);
		write_weight(16'h0000);
		run_phase(360, 61, 19, 1'b0);
		write_weight(16'($urandom_range(1, 65534)));
		run_phase(360, 0, 0, 1'b0);

		if (meter.errors == 0 && meter.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

>>> stereo_rms_level_meter.f
rtl/srms_pkg.sv
rtl/srms_sub_unit.sv
rtl/srms_mul_unit.sv
rtl/stereo_rms_level_meter.sv
sim/tb_stereo_rms_level_meter.sv
